/* design/mpq2k_pkg.sv */
package mpq2k_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [1:0] OP_INSERT_QUIET  = 2'd0;
   localparam logic [1:0] OP_INSERT_REPORT = 2'd1;
   localparam logic [1:0] OP_PEEK          = 2'd2;
   localparam logic [1:0] OP_POP           = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] name_tag;
      logic [15:0] roll;
      logic [15:0] mark;
   } req_type;

   typedef struct packed {
      logic        has_entry;
      logic [15:0] top_name_tag;
      logic [15:0] top_roll;
      logic [15:0] top_mark;
      logic        dropped_full;
   } rsp_type;

   typedef struct packed {
      logic [15:0] name_tag;
      logic [15:0] roll;
      logic [15:0] mark;
   } rec_type;

   // a strictly outranks b: larger mark, then smaller roll
   function automatic logic outranks(rec_type a, rec_type b);
      logic result;
      if (a.mark != b.mark) begin
         result = (a.mark > b.mark);
      end else begin
         result = (a.roll < b.roll);
      end
      return result;
   endfunction

endpackage

/* design/max_priority_queue_two_key.sv */
// Bounded max priority queue of (name tag, roll, mark) records, CAPACITY deep. The top is
// the record with the largest mark, then the smallest roll, then the oldest insertion.
// Records sit in a single-port-write, registered-read memory in insertion order, and the
// current top (record and slot) is cached in registers. An insert writes the new record
// and compares it once against the cached top; a peek only reads the cached top. The
// result beat is loaded into the output register from the report state, once that
// register is free. A pop makes one pass over the memory, one read per cycle through the
// registered read port, closes the gap left by the popped record and runs every survivor
// through the one shared comparator to find the new top. A quiet insert into a non-full
// queue gives no result beat; an insert into a full queue is dropped and reports the top
// with dropped_full set. An empty queue reports all zero fields. The next request is taken
// once the previous one has handed its beat to the output register.
module max_priority_queue_two_key (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mpq2k_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mpq2k_pkg::rsp_type  rsp_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_REPORT = 2'd2;

   localparam int IDX_W = mpq2k_pkg::IDX_W;
   localparam int CNT_W = mpq2k_pkg::CNT_W;

   // record store, in insertion order
   mpq2k_pkg::rec_type mem [mpq2k_pkg::CAPACITY];
   mpq2k_pkg::rec_type rd_data_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   mpq2k_pkg::rec_type mem_wd;

   // control and cached top
   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   top_idx_ff, top_idx_in;
   mpq2k_pkg::rec_type top_rec_ff, top_rec_in;
   logic               drop_ff, drop_in;

   // scan pass: read issue side and registered data side
   logic               issue_ff, issue_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               pv_ff, pv_in;
   logic [IDX_W-1:0]   p_idx_ff, p_idx_in;
   logic               p_last_ff, p_last_in;
   logic               best_valid_ff, best_valid_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   mpq2k_pkg::rec_type best_rec_ff, best_rec_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   mpq2k_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               is_insert;
   logic               full;
   logic               slot_free;
   logic               issue_last;
   logic [IDX_W-1:0]   new_idx;
   mpq2k_pkg::rec_type req_rec;

   // shared comparator operands
   mpq2k_pkg::rec_type cmp_a;
   mpq2k_pkg::rec_type cmp_b;
   logic               cmp_wins;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_insert = (req_data.op == mpq2k_pkg::OP_INSERT_QUIET) ||
                      (req_data.op == mpq2k_pkg::OP_INSERT_REPORT);
   assign full      = (count_ff == CNT_W'(mpq2k_pkg::CAPACITY));
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_rec   = '{name_tag: req_data.name_tag, roll: req_data.roll, mark: req_data.mark};

   // newcomer against cached top when idle, survivor against running best while scanning
   assign cmp_a    = (state_ff == ST_SCAN) ? rd_data_ff : req_rec;
   assign cmp_b    = (state_ff == ST_SCAN) ? best_rec_ff : top_rec_ff;
   assign cmp_wins = mpq2k_pkg::outranks(cmp_a, cmp_b);

   // last live slot reached by the read pointer
   assign issue_last = (CNT_W'(rd_idx_ff) == (count_ff - CNT_W'(1)));
   // slot of a survivor once the popped record's gap is closed
   assign new_idx = (p_idx_ff > top_idx_ff) ? (p_idx_ff - IDX_W'(1)) : p_idx_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      top_idx_in    = top_idx_ff;
      top_rec_in    = top_rec_ff;
      drop_in       = drop_ff;
      issue_in      = issue_ff;
      rd_idx_in     = rd_idx_ff;
      pv_in         = 1'b0;
      p_idx_in      = p_idx_ff;
      p_last_in     = p_last_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_rec_in   = best_rec_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_wa        = count_ff[IDX_W-1:0];
      mem_wd        = req_rec;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               drop_in = 1'b0;
               if (is_insert) begin
                  drop_in = full;
                  if (!full) begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                     // the newcomer is youngest, so it takes the top only by strict rank
                     if ((count_ff == '0) || cmp_wins) begin
                        top_rec_in = req_rec;
                        top_idx_in = count_ff[IDX_W-1:0];
                     end
                  end
                  if ((req_data.op == mpq2k_pkg::OP_INSERT_QUIET) && !full) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_REPORT;
                  end
               end else if ((req_data.op == mpq2k_pkg::OP_POP) && (count_ff != '0)) begin
                  state_in      = ST_SCAN;
                  issue_in      = 1'b1;
                  rd_idx_in     = '0;
                  best_valid_in = 1'b0;
               end else begin
                  state_in = ST_REPORT;
               end
            end
         end

         ST_SCAN: begin
            // issue side: one read per cycle
            if (issue_ff) begin
               pv_in     = 1'b1;
               p_idx_in  = rd_idx_ff;
               p_last_in = issue_last;
               if (issue_last) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
               end
            end
            // data side: move survivors down and rank them in age order
            if (pv_ff) begin
               if (p_idx_ff != top_idx_ff) begin
                  if (p_idx_ff > top_idx_ff) begin
                     mem_we = 1'b1;
                     mem_wa = new_idx;
                     mem_wd = rd_data_ff;
                  end
                  if (!best_valid_ff || cmp_wins) begin
                     best_valid_in = 1'b1;
                     best_idx_in   = new_idx;
                     best_rec_in   = rd_data_ff;
                  end
               end
               if (p_last_ff) begin
                  count_in   = count_ff - CNT_W'(1);
                  top_idx_in = best_idx_in;
                  top_rec_in = best_rec_in;
                  state_in   = ST_REPORT;
               end
            end
         end

         ST_REPORT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (count_ff != '0) begin
                  rsp_data_in.has_entry    = 1'b1;
                  rsp_data_in.top_name_tag = top_rec_ff.name_tag;
                  rsp_data_in.top_roll     = top_rec_ff.roll;
                  rsp_data_in.top_mark     = top_rec_ff.mark;
               end else begin
                  rsp_data_in.has_entry    = 1'b0;
                  rsp_data_in.top_name_tag = '0;
                  rsp_data_in.top_roll     = '0;
                  rsp_data_in.top_mark     = '0;
               end
               rsp_data_in.dropped_full = drop_ff;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // record memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_idx_ff];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         issue_ff      <= 1'b0;
         pv_ff         <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         issue_ff      <= issue_in;
         pv_ff         <= pv_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      top_idx_ff  <= top_idx_in;
      top_rec_ff  <= top_rec_in;
      drop_ff     <= drop_in;
      rd_idx_ff   <= rd_idx_in;
      p_idx_ff    <= p_idx_in;
      p_last_ff   <= p_last_in;
      best_idx_ff <= best_idx_in;
      best_rec_ff <= best_rec_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // fill level never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(mpq2k_pkg::CAPACITY))
      else $error("entry count above capacity");

   // a pop pass only runs over a nonempty store
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (count_ff != '0))
      else $error("scan pass with empty store");

   // an insert that fits grows the store by one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && is_insert && !full) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not add a record");

   // the end of a pop pass removes exactly one record
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && pv_ff && p_last_ff) |=>
         (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pop did not remove a record");

endmodule
